// ===== hw/rtl/sufx_pkg.sv =====
`timescale 1ns / 1ps

package sufx_pkg;

  // Channel payloads
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_of_packet;
  } in_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  ufrag_byte;
    logic [1:0]  verdict;
    logic [15:0] ufrag_length;
    logic        last;
  } out_t;

  typedef enum logic [1:0] {
    VrdFound     = 2'd0,
    VrdAbsent    = 2'd1,
    VrdMalformed = 2'd2
  } verdict_e;

  localparam logic KindUfrag   = 1'b0;
  localparam logic KindVerdict = 1'b1;

  localparam int unsigned PosW = 17;
  localparam logic [PosW-1:0] HdrLen = 17'd20;
  localparam logic [PosW-1:0] PosMax = 17'h1FFFF;
  localparam logic [7:0] ColonChar = 8'h3A;
  localparam logic [15:0] UserTypeRst = 16'd6;

  // Work item handed from parser to result serializer
  typedef struct packed {
    logic        byte_vld;
    logic [7:0]  ufrag_byte;
    logic        vrd_vld;
    verdict_e    verdict;
    logic [15:0] length;
  } entry_t;

endpackage

// ===== hw/rtl/sufx_front.sv =====
`timescale 1ns / 1ps

module sufx_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic [15:0]    cfg_wdata_i,
  input  logic           acc_i,
  input  sufx_pkg::in_t  item_i,
  output logic           push_o,
  output sufx_pkg::entry_t entry_o
);
  import sufx_pkg::*;

  localparam logic [2:0] PhHeader     = 3'd0;
  localparam logic [2:0] PhWalk       = 3'd1;
  localparam logic [2:0] PhEmit       = 3'd2;
  localparam logic [2:0] PhAfterColon = 3'd3;
  localparam logic [2:0] PhFinished   = 3'd4;

  logic [15:0]     utype_q;
  logic [PosW-1:0] pos_q, pos_d;
  logic [15:0]     mlen_q, mlen_d;
  logic [2:0]      phase_q, phase_d;
  logic [15:0]     atype_q, atype_d;
  logic [15:0]     alen_q, alen_d;
  logic [PosW-1:0] nas_q, nas_d;
  logic [15:0]     cnt_q, cnt_d;
  verdict_e        pend_q, pend_d;

  logic [17:0] msg_end, s_end4, val_end, pos_p1;
  logic [18:0] next_hdr;
  logic [15:0] alen_new;
  logic [17:0] alen_pad;
  logic [7:0]  b;
  logic        emit_byte;
  verdict_e    vrd;

  always_comb begin
    b         = item_i.data_byte;
    msg_end   = 18'(HdrLen) + 18'(mlen_q);
    s_end4    = 18'(nas_q) + 18'd4;
    alen_new  = {alen_q[15:8], b};
    val_end   = s_end4 + 18'(alen_new);
    alen_pad  = (18'(alen_new) + 18'd3) & ~18'd3;
    next_hdr  = 19'(s_end4) + 19'(alen_pad);
    pos_p1    = 18'(pos_q) + 18'd1;
    emit_byte = 1'b0;
    vrd       = VrdAbsent;

    pos_d   = pos_q;
    mlen_d  = mlen_q;
    phase_d = phase_q;
    atype_d = atype_q;
    alen_d  = alen_q;
    nas_d   = nas_q;
    cnt_d   = cnt_q;
    pend_d  = pend_q;

    case (phase_q)
      PhHeader: begin
        if (pos_q == 17'd2) begin
          mlen_d = {b, 8'h00};
        end else if (pos_q == 17'd3) begin
          mlen_d = {mlen_q[15:8], b};
        end else if (pos_q == 17'd19) begin
          nas_d = HdrLen;
          if (mlen_q < 16'd4) begin
            phase_d = PhFinished;
            pend_d  = VrdAbsent;
          end else begin
            phase_d = PhWalk;
          end
        end
      end
      PhWalk: begin
        if (pos_q >= nas_q && 18'(pos_q) < s_end4) begin
          case (2'(pos_q - nas_q))
            2'd0: atype_d = {b, 8'h00};
            2'd1: atype_d = {atype_q[15:8], b};
            2'd2: alen_d = {b, 8'h00};
            default: begin
              alen_d = alen_new;
              if (atype_q == utype_q) begin
                if (val_end > msg_end) begin
                  phase_d = PhFinished;
                  pend_d  = VrdMalformed;
                end else if (alen_new == 16'd0) begin
                  phase_d = PhFinished;
                  pend_d  = VrdFound;
                end else begin
                  nas_d   = val_end[PosW-1:0];
                  phase_d = PhEmit;
                end
              end else if (next_hdr + 19'd4 > 19'(msg_end)) begin
                phase_d = PhFinished;
                pend_d  = VrdAbsent;
              end else begin
                nas_d = next_hdr[PosW-1:0];
              end
            end
          endcase
        end
      end
      PhEmit, PhAfterColon: begin
        if (phase_q == PhEmit) begin
          if (b == ColonChar) begin
            phase_d = PhAfterColon;
          end else begin
            emit_byte = 1'b1;
            cnt_d     = cnt_q + 16'd1;
          end
        end
        if (pos_p1 >= 18'(nas_q)) begin
          phase_d = PhFinished;
          pend_d  = VrdFound;
        end
      end
      default: ;
    endcase

    if (pos_q != PosMax) begin
      pos_d = pos_q + 17'd1;
    end

    if (phase_d == PhFinished) begin
      vrd = pend_d;
    end else if (phase_d == PhEmit || phase_d == PhAfterColon) begin
      vrd = VrdMalformed;
    end else begin
      vrd = VrdAbsent;
    end

    entry_o.byte_vld   = emit_byte;
    entry_o.ufrag_byte = b;
    entry_o.vrd_vld    = item_i.last_of_packet;
    entry_o.verdict    = vrd;
    entry_o.length     = cnt_d;
    push_o = acc_i && (emit_byte || item_i.last_of_packet);

    // end of datagram: back to the header state
    if (item_i.last_of_packet) begin
      pos_d   = '0;
      mlen_d  = '0;
      phase_d = PhHeader;
      atype_d = '0;
      alen_d  = '0;
      nas_d   = HdrLen;
      cnt_d   = '0;
      pend_d  = VrdAbsent;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      utype_q <= UserTypeRst;
      pos_q   <= '0;
      mlen_q  <= '0;
      phase_q <= PhHeader;
      atype_q <= '0;
      alen_q  <= '0;
      nas_q   <= HdrLen;
      cnt_q   <= '0;
      pend_q  <= VrdAbsent;
    end else begin
      if (cfg_we_i) begin
        utype_q <= cfg_wdata_i;
      end
      if (acc_i) begin
        pos_q   <= pos_d;
        mlen_q  <= mlen_d;
        phase_q <= phase_d;
        atype_q <= atype_d;
        alen_q  <= alen_d;
        nas_q   <= nas_d;
        cnt_q   <= cnt_d;
        pend_q  <= pend_d;
      end
    end
  end

endmodule

// ===== hw/rtl/sufx_fifo.sv =====
`timescale 1ns / 1ps

module sufx_fifo #(
  parameter int unsigned Depth = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  sufx_pkg::entry_t  push_data_i,
  input  logic              pop_i,
  output sufx_pkg::entry_t  head_o,
  output logic              empty_o,
  output logic              full_o
);
  import sufx_pkg::*;

  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);
  localparam logic [AddrW-1:0] LastAddr = AddrW'(Depth - 1);
  localparam logic [CntW-1:0]  FullCnt  = CntW'(Depth);

  entry_t           mem_q [Depth];
  logic [AddrW-1:0] wr_q, rd_q;
  logic [CntW-1:0]  cnt_q;

  assign head_o  = mem_q[rd_q];
  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == FullCnt);

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == LastAddr) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == LastAddr) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ===== hw/rtl/sufx_back.sv =====
`timescale 1ns / 1ps

module sufx_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  sufx_pkg::entry_t head_i,
  input  logic             empty_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output sufx_pkg::out_t   out_data_o
);
  import sufx_pkg::*;

  logic out_vld_q, out_vld_d;
  logic byte_done_q, byte_done_d;
  out_t res_q, res_d;
  logic load, take;

  always_comb begin
    load        = !out_vld_q || !out_stall_i;
    take        = load && !empty_i;
    pop_o       = 1'b0;
    byte_done_d = byte_done_q;
    res_d       = res_q;

    if (head_i.byte_vld && !byte_done_q) begin
      res_d.kind         = KindUfrag;
      res_d.ufrag_byte   = head_i.ufrag_byte;
      res_d.verdict      = '0;
      res_d.ufrag_length = '0;
      res_d.last         = !head_i.vrd_vld;
      pop_o              = take && !head_i.vrd_vld;
      if (take && head_i.vrd_vld) begin
        byte_done_d = 1'b1;
      end
    end else begin
      res_d.kind         = KindVerdict;
      res_d.ufrag_byte   = '0;
      res_d.verdict      = head_i.verdict;
      res_d.ufrag_length = head_i.length;
      res_d.last         = 1'b1;
      pop_o              = take;
      if (take) begin
        byte_done_d = 1'b0;
      end
    end

    out_vld_d = take ? 1'b1 : (load ? 1'b0 : out_vld_q);
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q   <= 1'b0;
      byte_done_q <= 1'b0;
    end else begin
      out_vld_q   <= out_vld_d;
      byte_done_q <= byte_done_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = res_q;

endmodule

// ===== hw/rtl/stun_username_ufrag_extractor.sv =====
`timescale 1ns / 1ps
// A result passes through the result queue and then the registered output stage before it is valid at the output.
// Throughput: one datagram byte per cycle while the result queue is not full; the parser handles each byte in one step.
// A final byte that also yields a ufrag byte takes two output transactions (byte, then verdict);
// the result queue between parser and serializer absorbs that.
// Reset: USERNAME type code returns to 6, parser to the header state, queue and output empty.

module stun_username_ufrag_extractor #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  // configuration: USERNAME attribute type code
  input  logic            cfg_we_i,
  input  logic [15:0]     cfg_wdata_i,
  // datagram bytes
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  sufx_pkg::in_t   in_data_i,
  // ufrag bytes and verdicts
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output sufx_pkg::out_t  out_data_o
);
  import sufx_pkg::*;

  logic   in_acc;
  logic   push, pop, q_empty, q_full;
  entry_t push_entry, head_entry;

  // Stall comes from the registered queue fill, so it never depends on valid.
  assign in_stall_o = q_full;
  assign in_acc     = in_valid_i && !q_full;

  // Front: walks header and TLV attributes, one byte per transaction, and
  // queues at most one work entry per byte (ufrag byte and/or verdict).
  sufx_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .acc_i       (in_acc),
    .item_i      (in_data_i),
    .push_o      (push),
    .entry_o     (push_entry)
  );

  // Short queue decoupling the parser from output backpressure.
  sufx_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_entry),
    .pop_i       (pop),
    .head_o      (head_entry),
    .empty_o     (q_empty),
    .full_o      (q_full)
  );

  // Back: expands each entry into one or two result transactions through
  // a registered output stage.
  sufx_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head_entry),
    .empty_i     (q_empty),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
